/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define B64_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at a rising edge outside reset.
`define B64_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/b64c_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package b64c_pkg;

    typedef enum logic
    {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } mode_t;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Up to four result words produced by one input word.
    typedef struct packed
    {
        logic [3:0][7:0] syms;
        logic [2:0]      cnt;
        logic            has_data;
        logic            last;
    } group_t;

    function automatic logic [7:0] sym_of(input logic [5:0] v);
        logic [7:0] w;
        w = 8'(v);
        if (v < 6'd26)
        begin
            return w + 8'h41;
        end
        if (v < 6'd52)
        begin
            return w - 8'd26 + 8'h61;
        end
        if (v < 6'd62)
        begin
            return w - 8'd52 + 8'h30;
        end
        return (v == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    function automatic logic [5:0] val_of(input logic [7:0] c);
        logic [7:0] r;
        r = 8'd0;
        case (c) inside
            [8'h41:8'h5A]: r = c - 8'h41;
            [8'h61:8'h7A]: r = c - 8'h61 + 8'd26;
            [8'h30:8'h39]: r = c - 8'h30 + 8'd52;
            CHAR_PLUS:     r = 8'd62;
            CHAR_SLASH:    r = 8'd63;
            default:       r = 8'd0;
        endcase
        return r[5:0];
    endfunction

endpackage

`default_nettype wire

/* sv/base64_codec.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tdata = in_byte[7:0], tlast = in_last
// m_axis    out        tdata = out_byte[7:0], tuser = has_data, tlast = out_last
// cfg       in         cfg_data = mode (0 encode, 1 decode)
//
// One input word is translated in the cycle it is accepted and its results
// land in the output register on the next edge; a word with one result
// streams at one word per cycle while m_tready is high. A word with k results
// holds off the input while the output register drains them (k is at most 4).
// Reset returns to encode mode with the group state cleared.

module base64_codec
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // in_byte[7:0]
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // out_byte[7:0]
    output logic            m_tuser,    // has_data
    output logic            m_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);
    import b64c_pkg::*;

    group_t grp;
    logic   in_acc;
    logic   cfg_acc;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = s_tvalid && s_tready;

    b64c_xlate u_xlate
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_acc),
        .cfg_mode (cfg_data),
        .in_we    (in_acc),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .grp      (grp)
    );

    b64c_ser u_ser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_acc),
        .grp      (grp),
        .space    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* sv/b64c_xlate.sv */
`timescale 1ns / 1ps
`default_nettype none

module b64c_xlate
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_mode,
    input  wire logic            in_we,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_last,
    output b64c_pkg::group_t     grp
);
    import b64c_pkg::*;

    mode_t      mode_reg;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [5:0] carry_reg;
    logic [5:0] carry_next;
    logic       pad_reg;
    logic       pad_next;
    logic [1:0] ph;
    logic [5:0] v;
    logic [7:0] res;
    logic       have;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENC;
            phase_reg <= 2'd0;
            carry_reg <= 6'd0;
            pad_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg  <= mode_t'(cfg_mode);
            phase_reg <= 2'd0;
            carry_reg <= 6'd0;
            pad_reg   <= 1'b0;
        end
        else if (in_we)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
            pad_reg   <= pad_next;
        end
    end

    always_comb
    begin
        grp        = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        pad_next   = pad_reg;
        ph         = (phase_reg == 2'd3) ? 2'd0 : phase_reg;
        v          = val_of(in_byte);
        res        = 8'd0;
        have       = 1'b0;
        if (mode_reg == MODE_ENC)
        begin
            grp.has_data = 1'b1;
            grp.last     = in_last;
            case (ph)
                2'd0:
                begin
                    grp.syms[0] = sym_of(in_byte[7:2]);
                    carry_next  = {in_byte[1:0], 4'b0000};
                    phase_next  = 2'd1;
                    grp.cnt     = 3'd1;
                    if (in_last)
                    begin
                        grp.syms[1] = sym_of(carry_next);
                        grp.syms[2] = PAD_CHAR;
                        grp.syms[3] = PAD_CHAR;
                        grp.cnt     = 3'd4;
                    end
                end
                2'd1:
                begin
                    grp.syms[0] = sym_of({carry_reg[5:4], in_byte[7:4]});
                    carry_next  = {in_byte[3:0], 2'b00};
                    phase_next  = 2'd2;
                    grp.cnt     = 3'd1;
                    if (in_last)
                    begin
                        grp.syms[1] = sym_of(carry_next);
                        grp.syms[2] = PAD_CHAR;
                        grp.cnt     = 3'd3;
                    end
                end
                default:
                begin
                    grp.syms[0] = sym_of({carry_reg[5:2], in_byte[7:6]});
                    grp.syms[1] = sym_of(in_byte[5:0]);
                    carry_next  = 6'd0;
                    phase_next  = 2'd0;
                    grp.cnt     = 3'd2;
                end
            endcase
        end
        else
        begin
            if (!pad_reg)
            begin
                if (in_byte == PAD_CHAR)
                begin
                    pad_next   = 1'b1;
                    carry_next = 6'd0;
                end
                else
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            carry_next = v;
                        end
                        2'd1:
                        begin
                            res        = {carry_reg, v[5:4]};
                            carry_next = {2'b00, v[3:0]};
                            have       = 1'b1;
                        end
                        2'd2:
                        begin
                            res        = {carry_reg[3:0], v[5:2]};
                            carry_next = {4'b0000, v[1:0]};
                            have       = 1'b1;
                        end
                        default:
                        begin
                            res        = {carry_reg[1:0], v};
                            carry_next = 6'd0;
                            have       = 1'b1;
                        end
                    endcase
                    phase_next = phase_reg + 2'd1;
                end
            end
            if (have)
            begin
                grp.syms[0]  = res;
                grp.cnt      = 3'd1;
                grp.has_data = 1'b1;
                grp.last     = in_last;
            end
            else if (in_last)
            begin
                grp.cnt      = 3'd1;
                grp.has_data = 1'b0;
                grp.last     = 1'b1;
            end
        end
        if (in_last)
        begin
            phase_next = 2'd0;
            carry_next = 6'd0;
            pad_next   = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* sv/b64c_ser.sv */
`timescale 1ns / 1ps
`default_nettype none

module b64c_ser
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire b64c_pkg::group_t  grp,
    output logic                   space,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import b64c_pkg::*;

    logic [3:0][7:0] syms_reg;
    logic            hd_reg;
    logic            last_reg;
    logic [2:0]      cnt_reg;
    logic [1:0]      pos_reg;
    logic            take;

    assign m_tvalid = (cnt_reg != 3'd0);
    assign take     = m_tvalid && m_tready;
    assign space    = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);
    assign m_tdata  = syms_reg[pos_reg];
    assign m_tuser  = hd_reg;
    assign m_tlast  = last_reg && (cnt_reg == 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            pos_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= grp.cnt;
            pos_reg <= 2'd0;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 3'd1;
            pos_reg <= pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            syms_reg <= grp.syms;
            hd_reg   <= grp.has_data;
            last_reg <= grp.last;
        end
    end

endmodule

`default_nettype wire

/* sv/b64c_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module b64c_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    `B64_ASSERT(a_valid_holds, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")
    `B64_ASSERT(a_data_holds, clk, rst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata moved")
    `B64_NEVER(a_marker_last, clk, rst_n, m_tvalid && !m_tuser && !m_tlast, "marker not last")
    `B64_NEVER(a_marker_zero, clk, rst_n, m_tvalid && !m_tuser && (m_tdata != 8'd0), "marker data")
    `B64_NEVER(a_ready_empty, clk, rst_n, !m_tvalid && !s_tready, "input blocked while empty")

endmodule

bind base64_codec b64c_checker u_chk (.*);

`default_nettype wire
